// ===== rtl/core/msms_pkg.sv =====
// Shared types and constants of the move stack with masked search.
// Used by msms_ctrl, msms_dp and the top level; depends on nothing.
`default_nettype none

package msms_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DEST_SHIFT_DEF = 4;

    // Lane offsets of a promotion bundle: move+4 in the lowest lane up to move+7.
    localparam logic [63:0] PROMO_BUNDLE = 64'h0007_0006_0005_0004;

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_PROMO = 4'd1,
        CMD_POP   = 4'd2,
        CMD_TPOP  = 4'd3,
        CMD_READ  = 4'd4,
        CMD_FIND  = 4'd5,
        CMD_SWAP  = 4'd6,
        CMD_MOVE  = 4'd7,
        CMD_CLEAR = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_PUSH,
        DP_PROMO,
        DP_CLEAR,
        DP_RD_TOP,
        DP_RD_IDX,
        DP_TAKE_POP,
        DP_TAKE_READ,
        DP_SCAN,
        DP_TGT_HIT,
        DP_TGT_WR,
        DP_TGT_MISS,
        DP_FIND_HIT,
        DP_FIND_MISS,
        DP_SWAP_HIT,
        DP_SWAP_WR,
        DP_MOVE_HIT,
        DP_SHIFT,
        DP_MOVE_TOP,
        DP_NOT_FOUND,
        DP_EMPTY,
        DP_FULL,
        DP_RANGE,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic       cnt_zero;
        logic       full;
        logic       promo_fit;
        logic       ridx_ok;
        logic       eq_hit;
        logic       mask_hit;
        logic       ptr_zero;
        logic       ptr_is_top;
        logic       ptr_next_top;
        logic       lane_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/msms_dp.sv =====
// Datapath of the move stack: entry memory, fill count, scan pointer and result registers.
// Depends on msms_pkg; driven one operation per cycle by msms_ctrl.
`default_nettype none

module msms_dp #(
    parameter int DEPTH      = 256,
    parameter int DEST_SHIFT = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msms_pkg::dp_op_t  op,
    output msms_pkg::dp_stat_t     stat,
    input  wire logic [3:0]        command,
    input  wire logic [15:0]       move_word,
    input  wire logic [63:0]       target_mask,
    input  wire logic [7:0]        read_index,
    output logic [15:0]            word_out,
    output logic signed [8:0]      position,
    output logic                   found,
    output logic [8:0]             entry_count,
    output logic [2:0]             status
);
    import msms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > 9) ? CW : 9;
    localparam int PW = (AW > 9) ? AW : 9;
    localparam int RW = (CW > 8) ? CW : 8;

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rdata_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [1:0]    lane_reg, lane_next;
    logic [3:0]    cmd_reg;
    logic [15:0]   w_reg;
    logic [63:0]   mask_reg;
    logic [7:0]    ridx_reg;
    logic [63:0]   bundle_reg;

    logic [15:0]   res_word_reg;
    logic [8:0]    res_pos_reg;
    logic          res_found_reg;
    status_t       res_status_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [AW-1:0] top;
    logic [RW-1:0] ridx_ext;
    logic [RW-1:0] cnt_rw;
    logic [CW:0]   cnt_p4;
    logic [PW-1:0] ptr_ext;
    logic [EW-1:0] cnt_ext;
    logic [5:0]    dest;

    assign top      = cnt_reg[AW-1:0] - AW'(1);
    assign ridx_ext = RW'(ridx_reg);
    assign cnt_rw   = RW'(cnt_reg);
    assign cnt_p4   = {1'b0, cnt_reg} + (CW+1)'(4);
    assign ptr_ext  = PW'(ptr_reg);
    assign cnt_ext  = EW'(cnt_reg);
    assign dest     = rdata_reg[DEST_SHIFT +: 6];

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.cnt_zero     = (cnt_reg == '0);
        stat.full         = (cnt_reg == CW'(DEPTH));
        stat.promo_fit    = (cnt_p4 <= (CW+1)'(DEPTH));
        stat.ridx_ok      = (ridx_ext < cnt_rw);
        stat.eq_hit       = (rdata_reg == w_reg);
        stat.mask_hit     = mask_reg[dest];
        stat.ptr_zero     = (ptr_reg == '0);
        stat.ptr_is_top   = (ptr_reg == top);
        stat.ptr_next_top = ((ptr_reg + AW'(1)) == top);
        stat.lane_last    = (lane_reg == 2'd3);
    end

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = w_reg;
        mem_raddr = ptr_reg;
        unique case (op)
            DP_PUSH:
            begin
                mem_we = 1'b1;
            end
            DP_PROMO:
            begin
                mem_we    = 1'b1;
                mem_wdata = bundle_reg[16*lane_reg +: 16];
            end
            DP_RD_TOP:   mem_raddr = top;
            DP_RD_IDX:   mem_raddr = ridx_ext[AW-1:0];
            DP_SCAN:     mem_raddr = ptr_reg - AW'(1);
            DP_TGT_HIT:  mem_raddr = top;
            DP_TGT_WR, DP_SWAP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rdata_reg;
            end
            DP_SWAP_HIT:
            begin
                // The old top is read while the match takes its place.
                mem_we    = 1'b1;
                mem_waddr = top;
                mem_raddr = top;
            end
            DP_MOVE_HIT: mem_raddr = ptr_reg + AW'(1);
            DP_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rdata_reg;
                mem_raddr = ptr_reg + AW'(2);
            end
            DP_MOVE_TOP:
            begin
                mem_we    = 1'b1;
                mem_waddr = top;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        ptr_next  = ptr_reg;
        lane_next = lane_reg;
        unique case (op)
            DP_LOAD:     lane_next = 2'd0;
            DP_PUSH:     cnt_next = cnt_reg + CW'(1);
            DP_PROMO:
            begin
                cnt_next  = cnt_reg + CW'(1);
                lane_next = lane_reg + 2'd1;
            end
            DP_CLEAR:    cnt_next = '0;
            DP_RD_TOP:   ptr_next = top;
            DP_SCAN:     ptr_next = ptr_reg - AW'(1);
            DP_TAKE_POP, DP_TGT_WR: cnt_next = cnt_reg - CW'(1);
            DP_SHIFT:    ptr_next = ptr_reg + AW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers: input fields, scan state, staged result and output.
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        lane_reg <= lane_next;
        unique case (op)
            DP_LOAD:
            begin
                cmd_reg        <= command;
                w_reg          <= move_word;
                mask_reg       <= target_mask;
                ridx_reg       <= read_index;
                // Adding the word into every lane equals the multiply by 0x0001000100010001.
                bundle_reg     <= PROMO_BUNDLE + {4{move_word}};
                res_word_reg   <= '0;
                res_pos_reg    <= '0;
                res_found_reg  <= 1'b0;
                res_status_reg <= ST_OK;
            end
            DP_TAKE_POP, DP_TAKE_READ, DP_TGT_HIT: res_word_reg <= rdata_reg;
            DP_TGT_MISS:
            begin
                res_word_reg   <= 16'd1;
                res_status_reg <= ST_NOT_FOUND;
            end
            DP_FIND_HIT:  res_pos_reg <= ptr_ext[8:0];
            DP_FIND_MISS:
            begin
                res_pos_reg    <= '1;
                res_status_reg <= ST_NOT_FOUND;
            end
            DP_SWAP_HIT, DP_MOVE_HIT: res_found_reg <= 1'b1;
            DP_NOT_FOUND: res_status_reg <= ST_NOT_FOUND;
            DP_EMPTY:     res_status_reg <= ST_EMPTY;
            DP_FULL:      res_status_reg <= ST_FULL;
            DP_RANGE:     res_status_reg <= ST_RANGE;
            DP_PUBLISH:
            begin
                word_out    <= res_word_reg;
                position    <= res_pos_reg;
                found       <= res_found_reg;
                entry_count <= cnt_ext[8:0];
                status      <= res_status_reg;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/msms_ctrl.sv =====
// Controller state machine of the move stack: sequences datapath operations per command.
// Depends on msms_pkg; commands msms_dp and owns the handshake of both channels.
`default_nettype none

module msms_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire msms_pkg::dp_stat_t stat,
    output msms_pkg::dp_op_t        op
);
    import msms_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_PROMO    = 10'b00_0000_0100,
        S_TAKE     = 10'b00_0000_1000,
        S_SCAN     = 10'b00_0001_0000,
        S_TGT_WR   = 10'b00_0010_0000,
        S_SWAP_WR  = 10'b00_0100_0000,
        S_SHIFT    = 10'b00_1000_0000,
        S_MOVE_TOP = 10'b01_0000_0000,
        S_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   hit;

    // Result of a search that found nothing; an empty stack is reported apart for targeted pop.
    function automatic dp_op_t miss_op(input logic [3:0] cmd, input logic empty);
        dp_op_t r;
        r = DP_NOT_FOUND;
        if (cmd == CMD_TPOP)
        begin
            r = empty ? DP_EMPTY : DP_TGT_MISS;
        end
        else if (cmd == CMD_FIND)
        begin
            r = DP_FIND_MISS;
        end
        return r;
    endfunction

    assign hit       = (stat.cmd == CMD_TPOP) ? stat.mask_hit : stat.eq_hit;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = DP_IDLE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                unique case (stat.cmd)
                    CMD_PUSH:  op = stat.full ? DP_FULL : DP_PUSH;
                    CMD_PROMO:
                    begin
                        if (stat.promo_fit)
                        begin
                            state_next = S_PROMO;
                        end
                        else
                        begin
                            op = DP_FULL;
                        end
                    end
                    CMD_POP:
                    begin
                        if (stat.cnt_zero)
                        begin
                            op = DP_EMPTY;
                        end
                        else
                        begin
                            op         = DP_RD_TOP;
                            state_next = S_TAKE;
                        end
                    end
                    CMD_READ:
                    begin
                        if (stat.ridx_ok)
                        begin
                            op         = DP_RD_IDX;
                            state_next = S_TAKE;
                        end
                        else
                        begin
                            op = DP_RANGE;
                        end
                    end
                    CMD_TPOP, CMD_FIND, CMD_SWAP, CMD_MOVE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            op = miss_op(stat.cmd, 1'b1);
                        end
                        else
                        begin
                            op         = DP_RD_TOP;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_CLEAR: op = DP_CLEAR;
                    default:   op = DP_IDLE;
                endcase
            end
            S_PROMO:
            begin
                op = DP_PROMO;
                if (stat.lane_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_TAKE:
            begin
                op         = (stat.cmd == CMD_POP) ? DP_TAKE_POP : DP_TAKE_READ;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    unique case (stat.cmd)
                        CMD_TPOP:
                        begin
                            op         = DP_TGT_HIT;
                            state_next = S_TGT_WR;
                        end
                        CMD_SWAP:
                        begin
                            op         = DP_SWAP_HIT;
                            state_next = S_SWAP_WR;
                        end
                        CMD_MOVE:
                        begin
                            op         = DP_MOVE_HIT;
                            state_next = stat.ptr_is_top ? S_MOVE_TOP : S_SHIFT;
                        end
                        default:
                        begin
                            op         = DP_FIND_HIT;
                            state_next = S_FINISH;
                        end
                    endcase
                end
                else if (stat.ptr_zero)
                begin
                    op         = miss_op(stat.cmd, 1'b0);
                    state_next = S_FINISH;
                end
                else
                begin
                    op = DP_SCAN;
                end
            end
            S_TGT_WR:
            begin
                op         = DP_TGT_WR;
                state_next = S_FINISH;
            end
            S_SWAP_WR:
            begin
                op         = DP_SWAP_WR;
                state_next = S_FINISH;
            end
            S_SHIFT:
            begin
                op = DP_SHIFT;
                if (stat.ptr_next_top)
                begin
                    state_next = S_MOVE_TOP;
                end
            end
            S_MOVE_TOP:
            begin
                op         = DP_MOVE_TOP;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    op             = DP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/move_stack_with_masked_search.sv =====
// Move stack with masked search. After accept, each command passes a dispatch state and a
// finish state that publishes the result; pop and read add a take state after the read, a
// promotion bundle writes its four lanes in turn, and searches examine entries from the top,
// after which a swap and a targeted pop add a write state and move to top shifts each entry
// above the match. Only one item is in work at a time, until its result is published.
// Reset clears the fill count, controller and output valid; entry memory is not cleared.
`default_nettype none

module move_stack_with_masked_search #(
    parameter int DEPTH      = msms_pkg::DEPTH_DEF,
    parameter int DEST_SHIFT = msms_pkg::DEST_SHIFT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [3:0]         command,
    input  wire logic [15:0]        move_word,
    input  wire logic [63:0]        target_mask,
    input  wire logic [7:0]         read_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             word_out,
    output logic signed [8:0]       position,
    output logic                    found,
    output logic [8:0]              entry_count,
    output logic [2:0]              status
);
    import msms_pkg::*;

    // The controller issues one datapath operation per cycle and watches the flags the
    // datapath reports back. Searches read one entry per cycle from the single read port
    // of the entry memory, whose registered data is compared in the next cycle while the
    // following address is already presented.
    dp_op_t   dp_op;
    dp_stat_t dp_stat;

    msms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .op        (dp_op)
    );

    // The datapath latches the item's fields at accept, holds the stack memory and fill
    // count, and stages the result until the output register is free to take it.
    msms_dp #(
        .DEPTH      (DEPTH),
        .DEST_SHIFT (DEST_SHIFT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (dp_op),
        .stat        (dp_stat),
        .command     (command),
        .move_word   (move_word),
        .target_mask (target_mask),
        .read_index  (read_index),
        .word_out    (word_out),
        .position    (position),
        .found       (found),
        .entry_count (entry_count),
        .status      (status)
    );

`ifndef SYNTH
    // An accepted item keeps the block busy until its result is published.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice without a result in between");

    // A single push is never written into a full stack.
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        dp_op == DP_PUSH |-> !dp_stat.full)
        else $error("push written into a full stack");

    // Anything that lowers the fill count needs a stored entry.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_op == DP_TAKE_POP || dp_op == DP_TGT_WR) |-> !dp_stat.cnt_zero)
        else $error("pop on an empty stack");

    // Publishing a result always raises output valid in the next cycle.
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_op == DP_PUBLISH |=> out_valid)
        else $error("published result not presented");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_move_stack_with_masked_search.sv =====
// Self-checking testbench for move_stack_with_masked_search: it drives commands through the
// input handshake, predicts each result with a behavioral stack and checks every field.
// Depends on msms_pkg and the move_stack_with_masked_search RTL.
module tb_move_stack_with_masked_search;
    timeunit 1ns;
    timeprecision 1ps;

    import msms_pkg::*;

    localparam int          STACK_DEPTH  = DEPTH_DEF;
    localparam int          DEST_LSB     = DEST_SHIFT_DEF;
    // Adds the move word into each of the four 16-bit lanes of a promotion bundle.
    localparam logic [63:0] LANE_ONES    = 64'h0001_0001_0001_0001;
    // Command codes that the block must ignore.
    localparam logic [3:0]  CMD_SPARE_LO = 4'd9;
    localparam logic [3:0]  CMD_SPARE_HI = 4'd15;
    localparam int          IDLE_PERCENT = 28;
    localparam int          PRINT_LIMIT  = 40;
    localparam int          DRAIN_CYCLES = 20;
    // The slowest item walks and shifts a full stack; with about 1750 items and random stalls
    // on both sides the run stays well below this count.
    localparam longint      CYCLE_LIMIT  = 5_000_000;

    // One result item as the block presents it.
    typedef struct packed {
        logic [15:0] word;
        logic [8:0]  pos;
        logic        found;
        logic [8:0]  count;
        logic [2:0]  status;
    } stack_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [3:0]  command     = '0;
    logic [15:0] move_word   = '0;
    logic [63:0] target_mask = '0;
    logic [7:0]  read_index  = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] word_out;
    logic signed [8:0] position;
    logic        found;
    logic [8:0]  entry_count;
    logic [2:0]  status;

    // Shadow copy of the stack, updated in the order the block accepts items.
    logic [15:0]   stack_mem [STACK_DEPTH];
    int            stack_fill  = 0;
    stack_result_t pending_results[$];
    int            error_count = 0;
    longint        cycle_count = 0;
    // While set, neither side idles or stalls.
    bit            steady      = 1'b0;

    move_stack_with_masked_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .move_word   (move_word),
        .target_mask (target_mask),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .word_out    (word_out),
        .position    (position),
        .found       (found),
        .entry_count (entry_count),
        .status      (status)
    );

    always #5 clk = ~clk;

    // Index of the highest entry equal to the word, or -1.
    function automatic int find_from_top(logic [15:0] w);
        int hit;
        hit = -1;
        for (int k = stack_fill - 1; k >= 0 && hit < 0; k--)
        begin
            if (stack_mem[k] == w)
                hit = k;
        end
        return hit;
    endfunction

    // Mask with only the bit of the word's destination square set.
    function automatic logic [63:0] dest_bit(logic [15:0] w);
        return 64'b1 << w[DEST_LSB +: 6];
    endfunction

    // Runs one command on the shadow stack and returns the result the block should give.
    function automatic stack_result_t apply_command(logic [3:0] cmd, logic [15:0] w,
                                                    logic [63:0] mask, logic [7:0] idx);
        stack_result_t r;
        logic [63:0]   bundle;
        logic [15:0]   taken;
        int            hit;
        r   = '0;
        hit = -1;
        case (cmd)
            CMD_PUSH:
            begin
                if (stack_fill < STACK_DEPTH)
                begin
                    stack_mem[stack_fill] = w;
                    stack_fill++;
                end
                else
                    r.status = ST_FULL;
            end
            CMD_PROMO:
            begin
                // The bundle is one 64-bit sum, so a lane that wraps carries upward.
                if (stack_fill + 4 <= STACK_DEPTH)
                begin
                    bundle = PROMO_BUNDLE + {48'b0, w} * LANE_ONES;
                    for (int k = 0; k < 4; k++)
                    begin
                        stack_mem[stack_fill] = bundle[16 * k +: 16];
                        stack_fill++;
                    end
                end
                else
                    r.status = ST_FULL;
            end
            CMD_POP:
            begin
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    r.word = stack_mem[stack_fill];
                end
                else
                    r.status = ST_EMPTY;
            end
            CMD_TPOP:
            begin
                if (stack_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (int k = stack_fill - 1; k >= 0 && hit < 0; k--)
                    begin
                        if (mask[stack_mem[k][DEST_LSB +: 6]])
                            hit = k;
                    end
                    if (hit < 0)
                    begin
                        r.word   = 16'd1;
                        r.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        // The old top takes the place of the match, which leaves the stack.
                        taken          = stack_mem[hit];
                        stack_mem[hit] = stack_mem[stack_fill - 1];
                        stack_fill--;
                        r.word         = taken;
                    end
                end
            end
            CMD_READ:
            begin
                if (int'(idx) < stack_fill)
                    r.word = stack_mem[idx];
                else
                    r.status = ST_RANGE;
            end
            CMD_FIND:
            begin
                hit = find_from_top(w);
                if (hit >= 0)
                    r.pos = 9'(hit);
                else
                begin
                    r.pos    = '1;
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_SWAP:
            begin
                hit = find_from_top(w);
                if (hit >= 0)
                begin
                    stack_mem[hit]            = stack_mem[stack_fill - 1];
                    stack_mem[stack_fill - 1] = w;
                    r.found                   = 1'b1;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_MOVE:
            begin
                hit = find_from_top(w);
                if (hit >= 0)
                begin
                    for (int k = hit; k + 1 < stack_fill; k++)
                    begin
                        stack_mem[k] = stack_mem[k + 1];
                    end
                    stack_mem[stack_fill - 1] = w;
                    r.found                   = 1'b1;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_CLEAR:
                stack_fill = 0;
            default:
                ;
        endcase
        r.count = 9'(stack_fill);
        return r;
    endfunction

    // Word for a search: mostly one that is stored, sometimes a repeated or a fresh value.
    function automatic logic [15:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (stack_fill > 0 && roll < 65)
            return stack_mem[$urandom_range(stack_fill - 1)];
        else if (roll < 82)
            return 16'($urandom_range(7)) * 16'h1111;
        else
            return 16'($urandom);
    endfunction

    // Mask for a targeted pop, from a single stored destination up to all ones.
    function automatic logic [63:0] pick_mask();
        int roll;
        roll = $urandom_range(99);
        if (stack_fill > 0 && roll < 40)
            return dest_bit(stack_mem[$urandom_range(stack_fill - 1)]);
        else if (roll < 60)
            return 64'b1 << $urandom_range(63);
        else if (roll < 70)
            return '0;
        else if (roll < 75)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_index();
        if (stack_fill > 0 && $urandom_range(99) < 65)
            return 8'($urandom_range(stack_fill - 1));
        else
            return 8'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    // Presents one item, holds it until the block takes it, then records its expected result.
    // Valid is left high so that a following item can go out with no gap.
    task automatic send_item(logic [3:0] cmd, logic [15:0] w, logic [63:0] mask,
                             logic [7:0] idx);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        move_word   <= w;
        target_mask <= mask;
        read_index  <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_command(cmd, w, mask, idx));
    endtask

    // The receiving side stalls at random except during steady stretches.
    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Each accepted result is compared with the oldest expectation, field by field.
    always @(posedge clk)
    begin : check_result
        stack_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", word_out, 0);
            else
            begin
                want = pending_results.pop_front();
                if (word_out !== want.word)
                    report_mismatch("word_out", word_out, want.word);
                if (position !== want.pos)
                    report_mismatch("position", position, want.pos);
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", entry_count, want.count);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_move_stack_with_masked_search NOT OK");
            $finish;
        end
    end

    // Each command that reads or searches the stack, sent to an empty stack.
    task automatic test_empty_stack();
        send_item(CMD_POP, 16'h0000, '0, 8'd0);
        send_item(CMD_TPOP, 16'h0000, '1, 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd0);
        send_item(CMD_FIND, 16'h0000, '0, 8'd255);
        send_item(CMD_SWAP, 16'hFFFF, '0, 8'd0);
        send_item(CMD_MOVE, 16'h0000, '0, 8'd0);
    endtask

    // Each operation at least once on a small stack, with the field extremes and the corner cases.
    task automatic test_directed_ops();
        send_item(CMD_PUSH, 16'h0000, '0, 8'd0);
        send_item(CMD_PUSH, 16'hFFFF, '0, 8'd0);
        // Lanes wrap here and carry into the lane above.
        send_item(CMD_PROMO, 16'hFFFD, '0, 8'd0);
        send_item(CMD_PUSH, 16'h1234, '0, 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd6);
        // An index equal to the count and the largest index are both out of range.
        send_item(CMD_READ, 16'h0000, '0, 8'd7);
        send_item(CMD_READ, 16'h0000, '0, 8'd255);
        send_item(CMD_FIND, 16'h0000, '0, 8'd0);
        send_item(CMD_FIND, 16'hBEEF, '0, 8'd0);
        send_item(CMD_PUSH, 16'h0000, '0, 8'd0);
        // With a duplicate stored, the search must report the upper copy.
        send_item(CMD_FIND, 16'h0000, '0, 8'd0);
        send_item(CMD_SWAP, 16'hFFFF, '0, 8'd0);
        send_item(CMD_MOVE, stack_mem[3], '0, 8'd0);
        send_item(CMD_TPOP, 16'h0000, '0, 8'd0);
        send_item(CMD_TPOP, 16'h0000, dest_bit(16'h1234), 8'd0);
        send_item(CMD_TPOP, 16'h0000, '1, 8'd0);
        send_item(CMD_POP, 16'h0000, '0, 8'd0);
        send_item(CMD_SPARE_LO, 16'hFFFF, '1, 8'd255);
        send_item(CMD_SPARE_HI, 16'h0000, '0, 8'd0);
        send_item(CMD_CLEAR, 16'h0000, '0, 8'd0);
        send_item(CMD_POP, 16'h0000, '0, 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd0);
    endtask

    // Fills the stack exactly, checks that pushes are dropped and walks the full depth.
    task automatic test_full_stack();
        steady = 1'b1;
        send_item(CMD_CLEAR, 16'h0000, '0, 8'd0);
        repeat (STACK_DEPTH / 4)
            send_item(CMD_PROMO, 16'($urandom), '0, 8'd0);
        send_item(CMD_PUSH, 16'($urandom), '0, 8'd0);
        send_item(CMD_PROMO, 16'($urandom), '0, 8'd0);
        send_item(CMD_FIND, stack_mem[0], '0, 8'd0);
        send_item(CMD_MOVE, stack_mem[0], '0, 8'd0);
        send_item(CMD_SWAP, stack_mem[0], '0, 8'd0);
        send_item(CMD_TPOP, 16'h0000, dest_bit(stack_mem[0]), 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd255);
        // One free entry is not enough for a bundle, but a single push still fits.
        send_item(CMD_PROMO, 16'($urandom), '0, 8'd0);
        send_item(CMD_PUSH, 16'($urandom), '0, 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd255);
        send_item(CMD_CLEAR, 16'h0000, '0, 8'd0);
        steady = 1'b0;
    endtask

    // Random command mix; pushes turn into pops most of the time once the stack reaches the
    // given height, which keeps searches short except in the deep phase.
    task automatic test_random_traffic(int items, int ceiling);
        int          roll;
        logic [3:0]  cmd;
        logic [15:0] w;
        repeat (items)
        begin
            roll = $urandom_range(99);
            w    = pick_word();
            if (roll < 22)
            begin
                cmd = CMD_PUSH;
                if ($urandom_range(1) == 1)
                    w = 16'($urandom);
            end
            else if (roll < 30)
            begin
                cmd = CMD_PROMO;
                if ($urandom_range(9) == 0)
                    w = 16'hFFFC + 16'($urandom_range(3));
            end
            else if (roll < 42)
                cmd = CMD_POP;
            else if (roll < 56)
                cmd = CMD_TPOP;
            else if (roll < 66)
                cmd = CMD_READ;
            else if (roll < 76)
                cmd = CMD_FIND;
            else if (roll < 84)
                cmd = CMD_SWAP;
            else if (roll < 93)
                cmd = CMD_MOVE;
            else if (roll < 95)
                cmd = CMD_CLEAR;
            else if (roll < 97)
                cmd = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            else
            begin
                cmd = CMD_PUSH;
                w   = 16'($urandom);
            end
            if ((cmd == CMD_PUSH || cmd == CMD_PROMO) && stack_fill >= ceiling
                && $urandom_range(9) < 7)
                cmd = CMD_POP;
            send_item(cmd, w, pick_mask(), pick_index());
        end
    endtask

    // Builds a tall stack and runs random traffic near the top of the depth.
    task automatic test_deep_stack();
        send_item(CMD_CLEAR, 16'h0000, '0, 8'd0);
        while (stack_fill < 200)
            send_item(CMD_PROMO, pick_word(), '0, 8'd0);
        test_random_traffic(150, STACK_DEPTH);
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_directed_ops();
        test_full_stack();
        test_random_traffic(750, 48);
        // A long stretch in which neither side idles.
        steady = 1'b1;
        test_random_traffic(250, 48);
        steady = 1'b0;
        test_deep_stack();
        test_random_traffic(450, 24);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("tb_move_stack_with_masked_search OK");
        else
            $display("tb_move_stack_with_masked_search NOT OK");
        $finish;
    end

endmodule
